### src/ltok_pkg.sv
`default_nettype none

package ltok_pkg;

   // Width of the line and column counters; both saturate at all ones
   localparam int POS_BITS = 16;
   localparam logic [POS_BITS-1:0] POS_MAX = '1;
   localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

   // Fixed field widths of the channels
   localparam int CHAR_BITS  = 8;
   localparam int KIND_BITS  = 4;
   localparam int STAT_BITS  = 3;
   localparam int FIELD_BITS = 16;

   // Configuration port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_START_LINE   = 1'b0;
   localparam logic REG_START_COLUMN = 1'b1;
   localparam logic [FIELD_BITS-1:0] START_RESET = FIELD_BITS'(1);

   // Queue between front and back
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Character codes
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_X   = 8'h58;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_LO_A   = 8'h61;
   localparam logic [7:0] CH_LO_V   = 8'h76;
   localparam logic [7:0] CH_LO_X   = 8'h78;
   localparam logic [7:0] CH_LO_Z   = 8'h7A;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_BAR    = 8'h7C;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_TILDE  = 8'h7E;
   localparam logic [7:0] CH_NONE   = 8'h00;

   typedef enum logic [3:0] {
      PFX_IDLE, PFX_AMP, PFX_BAR, PFX_DASH, PFX_LT,
      PFX_LTDASH, PFX_EQ, PFX_BSL, PFX_COMMENT
   } prefix_type;

   typedef enum logic [KIND_BITS-1:0] {
      TOK_END, TOK_AND, TOK_OR, TOK_XOR, TOK_THEN, TOK_NOT, TOK_EQ, TOK_COLON,
      TOK_LPAREN, TOK_RPAREN, TOK_LBRACE, TOK_RBRACE, TOK_EOL, TOK_SYM, TOK_ERROR
   } kind_type;

   typedef enum logic [STAT_BITS-1:0] {
      ST_OK, ST_BSL_END, ST_END_IN_TOKEN, ST_BAD_AFTER_LT,
      ST_BAD_AFTER_LTDASH, ST_BAD_ESCAPE, ST_UNKNOWN
   } status_type;

   typedef struct packed {
      kind_type              kind;
      status_type            status;
      logic [CHAR_BITS-1:0]  letter;
      logic [POS_BITS-1:0]   line;
      logic [POS_BITS-1:0]   column;
   } token_type;

   // One queue entry holds every token that one input transaction causes
   typedef struct packed {
      logic      two;
      token_type tok0;
      token_type tok1;
   } entry_type;

   typedef struct packed {
      logic                  load_line;
      logic                  load_column;
      logic [FIELD_BITS-1:0] value;
   } cfg_load_type;

   function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
      if (v == POS_MAX) begin
         return v;
      end else begin
         return v + POS_ONE;
      end
   endfunction

   function automatic logic [POS_BITS-1:0] clamp_pos(input logic [FIELD_BITS-1:0] v);
      if (32'(v) > 32'(POS_MAX)) begin
         return POS_MAX;
      end else begin
         return POS_BITS'(v);
      end
   endfunction

   function automatic logic is_letter(input logic [CHAR_BITS-1:0] c);
      return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
   endfunction

   function automatic token_type make_tok(input kind_type kind, input status_type status,
                                          input logic [CHAR_BITS-1:0] letter,
                                          input logic [POS_BITS-1:0] line,
                                          input logic [POS_BITS-1:0] column);
      token_type t;
      t.kind   = kind;
      t.status = status;
      t.letter = letter;
      t.line   = line;
      t.column = column;
      return t;
   endfunction

endpackage

`default_nettype wire

### src/ltok_req_if.sv
`default_nettype none

interface ltok_req_if import ltok_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] char_code;
   logic                 end_of_input;

   modport source (output valid, char_code, end_of_input, input ready);
   modport sink   (input valid, char_code, end_of_input, output ready);
endinterface

`default_nettype wire

### src/ltok_rsp_if.sv
`default_nettype none

interface ltok_rsp_if import ltok_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [KIND_BITS-1:0]  token_kind;
   logic [STAT_BITS-1:0]  status;
   logic [CHAR_BITS-1:0]  symbol_letter;
   logic [FIELD_BITS-1:0] line_number;
   logic [FIELD_BITS-1:0] column_number;
   logic                  last;

   modport source (output valid, token_kind, status, symbol_letter, line_number,
                   column_number, last, input ready);
   modport sink   (input valid, token_kind, status, symbol_letter, line_number,
                   column_number, last, output ready);
endinterface

`default_nettype wire

### src/logic_expression_tokenizer.sv
// An accepted byte's tokens are registered in the queue, then in the output register.
// Throughput: one byte per cycle while the queue has room; a byte yielding two tokens
// holds the output stage for both, absorbed by a four-entry queue between tokenizer
// and output. Bytes that give no token (blanks, comments, prefixes) emit nothing.
// Reset (synchronous): start registers and both counters to 1, no prefix pending,
// end and error flags clear, queue and output stage empty.
`default_nettype none

module logic_expression_tokenizer import ltok_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   ltok_req_if.sink                      req_chan,
   ltok_rsp_if.source                    rsp_chan,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output      logic [CSR_DATA_BITS-1:0] prdata,
   output      logic                     pready
);

   cfg_load_type cfg;
   logic         push_valid;
   logic         push_ready;
   entry_type    push_data;
   logic         pop_valid;
   logic         pop_ready;
   entry_type    pop_data;

   ltok_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ltok_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ltok_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ltok_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

### src/ltok_csr.sv
`default_nettype none

module ltok_csr import ltok_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output      logic [CSR_DATA_BITS-1:0] prdata,
   output      logic                     pready,
   output      cfg_load_type             cfg
);

   logic [FIELD_BITS-1:0] start_line_ff, start_line_in;
   logic [FIELD_BITS-1:0] start_column_ff, start_column_in;
   logic                  wr_en;
   logic                  reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[2];

   // Register writes; a write also reloads the matching position counter
   always_comb begin
      start_line_in   = start_line_ff;
      start_column_in = start_column_ff;
      cfg.load_line   = 1'b0;
      cfg.load_column = 1'b0;
      cfg.value       = pwdata[FIELD_BITS-1:0];
      if (wr_en) begin
         case (reg_sel)
            REG_START_LINE: begin
               start_line_in = pwdata[FIELD_BITS-1:0];
               cfg.load_line = 1'b1;
            end
            REG_START_COLUMN: begin
               start_column_in = pwdata[FIELD_BITS-1:0];
               cfg.load_column = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Read mux
   always_comb begin
      case (reg_sel)
         REG_START_LINE:   prdata = CSR_DATA_BITS'(start_line_ff);
         REG_START_COLUMN: prdata = CSR_DATA_BITS'(start_column_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_line_ff   <= START_RESET;
         start_column_ff <= START_RESET;
      end else begin
         start_line_ff   <= start_line_in;
         start_column_ff <= start_column_in;
      end
   end

endmodule

`default_nettype wire

### src/ltok_front.sv
`default_nettype none

module ltok_front import ltok_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   ltok_req_if.sink          req_chan,
   input  wire cfg_load_type cfg,
   output      logic         push_valid,
   input  wire logic         push_ready,
   output      entry_type    push_data
);

   prefix_type          prefix_ff, prefix_in;
   logic [POS_BITS-1:0] line_ff, line_in;
   logic [POS_BITS-1:0] col_ff, col_in;
   logic                finished_ff, finished_in;
   logic                failed_ff, failed_in;

   logic                 accept;
   logic [CHAR_BITS-1:0] c;
   logic                 eoi;
   logic [POS_BITS-1:0]  col_a;

   // Fresh-byte decode
   logic                 fr_emit;
   kind_type             fr_kind;
   status_type           fr_status;
   logic [CHAR_BITS-1:0] fr_letter;
   prefix_type           fr_prefix;
   logic                 fr_newline;
   logic [POS_BITS-1:0]  fr_line;
   logic [POS_BITS-1:0]  fr_col;
   token_type            fr_tok;

   // Pair prefix parameters
   logic [CHAR_BITS-1:0] pair_second;
   kind_type             pair_long;
   kind_type             pair_short;

   // Per-transaction outcome
   prefix_type          prefix_v;
   logic [POS_BITS-1:0] line_v;
   logic [POS_BITS-1:0] col_v;
   logic                any_v;
   logic                two_v;
   token_type           tok0_v;
   token_type           tok1_v;

   assign c              = req_chan.char_code;
   assign eoi            = req_chan.end_of_input;
   assign req_chan.ready = push_ready;
   assign accept         = req_chan.valid && push_ready;
   assign col_a          = sat_inc(col_ff);

   // Classify a byte seen with no prefix pending
   always_comb begin
      fr_emit    = 1'b1;
      fr_kind    = TOK_ERROR;
      fr_status  = ST_OK;
      fr_letter  = CH_NONE;
      fr_prefix  = PFX_IDLE;
      fr_newline = 1'b0;
      case (c) inside
         CH_CARET:                  fr_kind = TOK_AND;
         CH_AMP:                    begin fr_emit = 1'b0; fr_prefix = PFX_AMP; end
         CH_LO_V:                   fr_kind = TOK_OR;
         CH_BAR:                    begin fr_emit = 1'b0; fr_prefix = PFX_BAR; end
         CH_LO_X, CH_UP_X, CH_PLUS: fr_kind = TOK_XOR;
         CH_DASH:                   begin fr_emit = 1'b0; fr_prefix = PFX_DASH; end
         CH_BANG, CH_TILDE:         fr_kind = TOK_NOT;
         CH_LT:                     begin fr_emit = 1'b0; fr_prefix = PFX_LT; end
         CH_EQ:                     begin fr_emit = 1'b0; fr_prefix = PFX_EQ; end
         CH_COLON:                  fr_kind = TOK_COLON;
         CH_LPAREN:                 fr_kind = TOK_LPAREN;
         CH_RPAREN:                 fr_kind = TOK_RPAREN;
         CH_LBRACE:                 fr_kind = TOK_LBRACE;
         CH_RBRACE:                 fr_kind = TOK_RBRACE;
         CH_LF:                     begin fr_kind = TOK_EOL; fr_newline = 1'b1; end
         CH_SEMI:                   fr_kind = TOK_EOL;
         CH_HASH:                   begin fr_emit = 1'b0; fr_prefix = PFX_COMMENT; end
         CH_BSLASH:                 begin fr_emit = 1'b0; fr_prefix = PFX_BSL; end
         CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR: fr_emit = 1'b0;
         [CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]: begin
            fr_kind   = TOK_SYM;
            fr_letter = c;
         end
         default: begin
            fr_kind   = TOK_ERROR;
            fr_status = ST_UNKNOWN;
            fr_letter = c;
         end
      endcase
   end

   assign fr_line = fr_newline ? sat_inc(line_ff) : line_ff;
   assign fr_col  = fr_newline ? '0 : col_a;
   assign fr_tok  = make_tok(fr_kind, fr_status, fr_letter, fr_line, fr_col);

   // Second byte and token kinds of the two-byte operators
   always_comb begin
      case (prefix_ff)
         PFX_AMP:  begin pair_second = CH_AMP;  pair_long = TOK_AND;  pair_short = TOK_AND; end
         PFX_BAR:  begin pair_second = CH_BAR;  pair_long = TOK_OR;   pair_short = TOK_OR;  end
         PFX_EQ:   begin pair_second = CH_EQ;   pair_long = TOK_EQ;   pair_short = TOK_EQ;  end
         PFX_DASH: begin pair_second = CH_GT;   pair_long = TOK_THEN; pair_short = TOK_NOT; end
         default:  begin pair_second = CH_NONE; pair_long = TOK_END;  pair_short = TOK_END; end
      endcase
   end

   // Token generation for one transaction
   always_comb begin
      prefix_v = prefix_ff;
      line_v   = line_ff;
      col_v    = col_ff;
      any_v    = 1'b0;
      two_v    = 1'b0;
      tok0_v   = '0;
      tok1_v   = '0;
      if (failed_ff) begin
         any_v = 1'b0;
      end else if (finished_ff) begin
         any_v  = 1'b1;
         tok0_v = make_tok(TOK_END, ST_OK, CH_NONE, line_ff, col_ff);
      end else begin
         case (prefix_ff)
            PFX_AMP, PFX_BAR, PFX_EQ, PFX_DASH: begin
               prefix_v = PFX_IDLE;
               any_v    = 1'b1;
               if (eoi) begin
                  two_v  = 1'b1;
                  tok0_v = make_tok(pair_short, ST_OK, CH_NONE, line_ff, col_ff);
                  tok1_v = make_tok(TOK_END, ST_OK, CH_NONE, line_ff, col_ff);
               end else if (c == pair_second) begin
                  col_v  = col_a;
                  tok0_v = make_tok(pair_long, ST_OK, CH_NONE, line_ff, col_a);
               end else begin
                  // lookahead rejected: short token, then the byte again
                  tok0_v   = make_tok(pair_short, ST_OK, CH_NONE, line_ff, col_ff);
                  prefix_v = fr_prefix;
                  line_v   = fr_line;
                  col_v    = fr_col;
                  two_v    = fr_emit;
                  tok1_v   = fr_tok;
               end
            end
            PFX_LT: begin
               prefix_v = PFX_IDLE;
               col_v    = col_a;
               if (eoi) begin
                  any_v  = 1'b1;
                  tok0_v = make_tok(TOK_ERROR, ST_END_IN_TOKEN, CH_NONE, line_ff, col_a);
               end else if (c == CH_DASH) begin
                  prefix_v = PFX_LTDASH;
               end else begin
                  any_v  = 1'b1;
                  tok0_v = make_tok(TOK_ERROR, ST_BAD_AFTER_LT, c, line_ff, col_a);
               end
            end
            PFX_LTDASH: begin
               prefix_v = PFX_IDLE;
               col_v    = col_a;
               any_v    = 1'b1;
               if (eoi) begin
                  tok0_v = make_tok(TOK_ERROR, ST_END_IN_TOKEN, CH_NONE, line_ff, col_a);
               end else if (c == CH_GT) begin
                  tok0_v = make_tok(TOK_EQ, ST_OK, CH_NONE, line_ff, col_a);
               end else begin
                  tok0_v = make_tok(TOK_ERROR, ST_BAD_AFTER_LTDASH, c, line_ff, col_a);
               end
            end
            PFX_BSL: begin
               prefix_v = PFX_IDLE;
               col_v    = col_a;
               if (eoi) begin
                  any_v  = 1'b1;
                  tok0_v = make_tok(TOK_END, ST_BSL_END, CH_NONE, line_ff, col_a);
               end else if (c == CH_LF) begin
                  line_v = sat_inc(line_ff);
                  col_v  = '0;
               end else if (is_letter(c)) begin
                  any_v  = 1'b1;
                  tok0_v = make_tok(TOK_SYM, ST_OK, c, line_ff, col_a);
               end else begin
                  any_v  = 1'b1;
                  tok0_v = make_tok(TOK_ERROR, ST_BAD_ESCAPE, c, line_ff, col_a);
               end
            end
            PFX_COMMENT: begin
               col_v = col_a;
               if (eoi) begin
                  // line counted, column restarts at one
                  prefix_v = PFX_IDLE;
                  line_v   = sat_inc(line_ff);
                  col_v    = POS_ONE;
                  any_v    = 1'b1;
                  tok0_v   = make_tok(TOK_END, ST_OK, CH_NONE, sat_inc(line_ff), POS_ONE);
               end else if (c == CH_LF) begin
                  prefix_v = PFX_IDLE;
                  line_v   = sat_inc(line_ff);
                  col_v    = '0;
               end
            end
            default: begin
               prefix_v = PFX_IDLE;
               if (eoi) begin
                  col_v  = col_a;
                  any_v  = 1'b1;
                  tok0_v = make_tok(TOK_END, ST_OK, CH_NONE, line_ff, col_a);
               end else begin
                  prefix_v = fr_prefix;
                  line_v   = fr_line;
                  col_v    = fr_col;
                  any_v    = fr_emit;
                  tok0_v   = fr_tok;
               end
            end
         endcase
      end
   end

   // Next state; a configuration write reloads its counter
   always_comb begin
      prefix_in   = prefix_ff;
      line_in     = line_ff;
      col_in      = col_ff;
      finished_in = finished_ff;
      failed_in   = failed_ff;
      if (accept) begin
         prefix_in   = prefix_v;
         line_in     = line_v;
         col_in      = col_v;
         finished_in = finished_ff || (any_v && (tok0_v.kind == TOK_END))
                       || (two_v && (tok1_v.kind == TOK_END));
         failed_in   = failed_ff || (any_v && (tok0_v.kind == TOK_ERROR))
                       || (two_v && (tok1_v.kind == TOK_ERROR));
      end
      if (cfg.load_line) begin
         line_in = clamp_pos(cfg.value);
      end
      if (cfg.load_column) begin
         col_in = clamp_pos(cfg.value);
      end
   end

   assign push_valid     = req_chan.valid && any_v;
   assign push_data.two  = two_v;
   assign push_data.tok0 = tok0_v;
   assign push_data.tok1 = tok1_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff   <= PFX_IDLE;
         line_ff     <= clamp_pos(START_RESET);
         col_ff      <= clamp_pos(START_RESET);
         finished_ff <= 1'b0;
         failed_ff   <= 1'b0;
      end else begin
         prefix_ff   <= prefix_in;
         line_ff     <= line_in;
         col_ff      <= col_in;
         finished_ff <= finished_in;
         failed_ff   <= failed_in;
      end
   end

   // An error is sticky
   a_failed_sticky: assert property (@(posedge clock) disable iff (reset)
      failed_ff |=> failed_ff)
      else $error("failed flag cleared without reset");

   // After an end token no error can follow, and the reverse
   a_end_err_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(finished_ff && failed_ff))
      else $error("finished and failed both set");

endmodule

`default_nettype wire

### src/ltok_queue.sv
`default_nettype none

module ltok_queue import ltok_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   output      logic      push_ready,
   input  wire entry_type push_data,
   output      logic      pop_valid,
   input  wire logic      pop_ready,
   output      entry_type pop_data
);

   entry_type                 mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign push_ready = (count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

   // Pointers stay apart by the fill count, modulo the queue depth
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[QUEUE_PTR_BITS-1:0])
      else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

### src/ltok_back.sv
`default_nettype none

module ltok_back import ltok_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      pop_valid,
   output      logic      pop_ready,
   input  wire entry_type pop_data,
   ltok_rsp_if.source     rsp_chan
);

   logic      out_valid_ff, out_valid_in;
   logic      sub_ff, sub_in;
   token_type out_tok_ff;
   logic      out_last_ff;
   logic      load;
   logic      issue;
   logic      is_last;
   token_type sel_tok;

   // Output register loads when empty or being taken
   assign load      = !out_valid_ff || rsp_chan.ready;
   assign issue     = load && pop_valid;
   assign is_last   = !pop_data.two || sub_ff;
   assign sel_tok   = sub_ff ? pop_data.tok1 : pop_data.tok0;
   assign pop_ready = load && is_last;

   always_comb begin
      out_valid_in = load ? pop_valid : out_valid_ff;
      sub_in       = issue ? (pop_data.two && !sub_ff) : sub_ff;
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         out_tok_ff  <= sel_tok;
         out_last_ff <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sub_ff       <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         sub_ff       <= sub_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.token_kind    = out_tok_ff.kind;
   assign rsp_chan.status        = out_tok_ff.status;
   assign rsp_chan.symbol_letter = out_tok_ff.letter;
   assign rsp_chan.line_number   = FIELD_BITS'(out_tok_ff.line);
   assign rsp_chan.column_number = FIELD_BITS'(out_tok_ff.column);
   assign rsp_chan.last          = out_last_ff;

   // Second token pending only while a two-token entry heads the queue
   a_sub_has_entry: assert property (@(posedge clock) disable iff (reset)
      sub_ff |-> (pop_valid && pop_data.two))
      else $error("second-token flag without a two-token entry");

   // The second token of an entry follows its first directly
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last) |=> rsp_chan.valid)
      else $error("second token did not follow the first");

endmodule

`default_nettype wire

### tb/sv/ltok_tb_pkg.sv
`default_nettype none

package ltok_tb_pkg;
   import ltok_pkg::*;

   // One token as it leaves the block, plus the end-of-transaction flag
   typedef struct {
      kind_type             kind;
      status_type           status;
      logic [CHAR_BITS-1:0] letter;
      logic [POS_BITS-1:0]  line;
      logic [POS_BITS-1:0]  column;
      logic                 last;
   } tok_rec_type;

   // Tracks tokenizer state and the tokens still owed by the block
   class token_checker;
      prefix_type            pfx;
      logic [POS_BITS-1:0]   line_cnt;
      logic [POS_BITS-1:0]   col_cnt;
      logic [FIELD_BITS-1:0] start_line;
      logic [FIELD_BITS-1:0] start_col;
      bit                    done;
      bit                    dead;
      int                    item_toks;
      int                    errors;
      tok_rec_type           tokens_due[$];

      function new();
         start_line = START_RESET;
         start_col  = START_RESET;
         pfx        = PFX_IDLE;
         line_cnt   = start_line;
         col_cnt    = start_col;
         done       = 0;
         dead       = 0;
         errors     = 0;
      endfunction

      function void write_reg(logic idx, logic [FIELD_BITS-1:0] value);
         if (idx == REG_START_LINE) begin
            start_line = value;
            line_cnt   = value;
         end else begin
            start_col = value;
            col_cnt   = value;
         end
      endfunction

      function int outstanding();
         return tokens_due.size();
      endfunction

      function bit is_alpha(logic [CHAR_BITS-1:0] c);
         return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
      endfunction

      // Counters stick at all ones
      function void bump_col();
         if (col_cnt != '1) col_cnt++;
      endfunction

      function void next_line();
         if (line_cnt != '1) line_cnt++;
         col_cnt = '0;
      endfunction

      function void add_tok(kind_type k, status_type s, logic [CHAR_BITS-1:0] l);
         tok_rec_type t;
         t.kind   = k;
         t.status = s;
         t.letter = l;
         t.line   = line_cnt;
         t.column = col_cnt;
         t.last   = 1'b0;
         tokens_due.push_back(t);
         item_toks++;
         if (k == TOK_END) done = 1;
         if (k == TOK_ERROR) dead = 1;
      endfunction

      // Byte seen with no prefix pending
      function void plain_byte(logic [CHAR_BITS-1:0] c);
         bump_col();
         case (c)
            CH_CARET:                       add_tok(TOK_AND, ST_OK, CH_NONE);
            CH_AMP:                         pfx = PFX_AMP;
            CH_LO_V:                        add_tok(TOK_OR, ST_OK, CH_NONE);
            CH_BAR:                         pfx = PFX_BAR;
            CH_LO_X, CH_UP_X, CH_PLUS:      add_tok(TOK_XOR, ST_OK, CH_NONE);
            CH_DASH:                        pfx = PFX_DASH;
            CH_BANG, CH_TILDE:              add_tok(TOK_NOT, ST_OK, CH_NONE);
            CH_LT:                          pfx = PFX_LT;
            CH_EQ:                          pfx = PFX_EQ;
            CH_COLON:                       add_tok(TOK_COLON, ST_OK, CH_NONE);
            CH_LPAREN:                      add_tok(TOK_LPAREN, ST_OK, CH_NONE);
            CH_RPAREN:                      add_tok(TOK_RPAREN, ST_OK, CH_NONE);
            CH_LBRACE:                      add_tok(TOK_LBRACE, ST_OK, CH_NONE);
            CH_RBRACE:                      add_tok(TOK_RBRACE, ST_OK, CH_NONE);
            CH_LF: begin
               next_line();
               add_tok(TOK_EOL, ST_OK, CH_NONE);
            end
            CH_SEMI:                        add_tok(TOK_EOL, ST_OK, CH_NONE);
            CH_HASH:                        pfx = PFX_COMMENT;
            CH_BSLASH:                      pfx = PFX_BSL;
            CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR: ;
            default: begin
               if (is_alpha(c)) add_tok(TOK_SYM, ST_OK, c);
               else add_tok(TOK_ERROR, ST_UNKNOWN, c);
            end
         endcase
      endfunction

      // One-byte prefix: completes with 'second', else short token and byte redone
      function void pair_step(logic [CHAR_BITS-1:0] c, bit eoi, logic [CHAR_BITS-1:0] second,
                              kind_type long_k, kind_type short_k);
         pfx = PFX_IDLE;
         if (eoi) begin
            add_tok(short_k, ST_OK, CH_NONE);
            add_tok(TOK_END, ST_OK, CH_NONE);
         end else if (c == second) begin
            bump_col();
            add_tok(long_k, ST_OK, CH_NONE);
         end else begin
            add_tok(short_k, ST_OK, CH_NONE);
            plain_byte(c);
         end
      endfunction

      // Accepted input transaction: queue the tokens it must cause
      function void take_byte(logic [CHAR_BITS-1:0] c, bit eoi);
         tok_rec_type t;
         item_toks = 0;
         if (dead) return;
         if (done) begin
            add_tok(TOK_END, ST_OK, CH_NONE);
         end else begin
            case (pfx)
               PFX_AMP:  pair_step(c, eoi, CH_AMP, TOK_AND, TOK_AND);
               PFX_BAR:  pair_step(c, eoi, CH_BAR, TOK_OR, TOK_OR);
               PFX_EQ:   pair_step(c, eoi, CH_EQ, TOK_EQ, TOK_EQ);
               PFX_DASH: pair_step(c, eoi, CH_GT, TOK_THEN, TOK_NOT);
               PFX_LT: begin
                  bump_col();
                  pfx = PFX_IDLE;
                  if (eoi) add_tok(TOK_ERROR, ST_END_IN_TOKEN, CH_NONE);
                  else if (c == CH_DASH) pfx = PFX_LTDASH;
                  else add_tok(TOK_ERROR, ST_BAD_AFTER_LT, c);
               end
               PFX_LTDASH: begin
                  bump_col();
                  pfx = PFX_IDLE;
                  if (eoi) add_tok(TOK_ERROR, ST_END_IN_TOKEN, CH_NONE);
                  else if (c == CH_GT) add_tok(TOK_EQ, ST_OK, CH_NONE);
                  else add_tok(TOK_ERROR, ST_BAD_AFTER_LTDASH, c);
               end
               PFX_BSL: begin
                  bump_col();
                  pfx = PFX_IDLE;
                  if (eoi) add_tok(TOK_END, ST_BSL_END, CH_NONE);
                  else if (c == CH_LF) next_line();
                  else if (is_alpha(c)) add_tok(TOK_SYM, ST_OK, c);
                  else add_tok(TOK_ERROR, ST_BAD_ESCAPE, c);
               end
               PFX_COMMENT: begin
                  bump_col();
                  if (eoi) begin
                     pfx = PFX_IDLE;
                     next_line();
                     bump_col();
                     add_tok(TOK_END, ST_OK, CH_NONE);
                  end else if (c == CH_LF) begin
                     pfx = PFX_IDLE;
                     next_line();
                  end
               end
               default: begin
                  pfx = PFX_IDLE;
                  if (eoi) begin
                     bump_col();
                     add_tok(TOK_END, ST_OK, CH_NONE);
                  end else begin
                     plain_byte(c);
                  end
               end
            endcase
         end
         // flag the final token of this transaction
         if (item_toks > 0) begin
            t = tokens_due.pop_back();
            t.last = 1'b1;
            tokens_due.push_back(t);
         end
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      // Accepted result transaction against the oldest token owed
      function void match_token(tok_rec_type got);
         tok_rec_type want;
         if (tokens_due.size() == 0) begin
            $error("token_kind: expected none, actual %0d", got.kind);
            errors++;
            return;
         end
         want = tokens_due.pop_front();
         compare_field("token_kind", 16'(want.kind), 16'(got.kind));
         compare_field("status", 16'(want.status), 16'(got.status));
         compare_field("symbol_letter", 16'(want.letter), 16'(got.letter));
         compare_field("line_number", want.line, got.line);
         compare_field("column_number", want.column, got.column);
         compare_field("last", 16'(want.last), 16'(got.last));
      endfunction
   endclass

endpackage

`default_nettype wire

### tb/sv/tb_top.sv
`default_nettype none

module tb_top;
   import ltok_pkg::*;
   import ltok_tb_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PHASES         = 6;
   localparam int PHASE_BYTES    = 236;
   localparam int TAIL_BYTES     = 100;

   // Opening text: every operator, rejected lookahead, escape, comment with extreme bytes
   localparam logic [7:0] INTRO [28] = '{
      CH_UP_A, CH_AMP, CH_AMP, CH_LO_Z, CH_BAR, CH_LPAREN, CH_DASH, CH_GT,
      CH_LT, CH_DASH, CH_GT, CH_EQ, CH_EQ, CH_CARET, CH_LO_V, CH_PLUS,
      CH_TILDE, CH_DASH, CH_RPAREN, CH_BSLASH, CH_LF, CH_HASH, 8'h00, 8'hFF,
      CH_LF, CH_LBRACE, CH_EQ, CH_RBRACE
   };
   localparam logic [7:0] SINGLE_OPS [13] = '{
      CH_CARET, CH_LO_V, CH_LO_X, CH_UP_X, CH_PLUS, CH_BANG, CH_TILDE,
      CH_COLON, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_SEMI
   };
   localparam logic [7:0] PREFIXES [4] = '{CH_AMP, CH_BAR, CH_DASH, CH_EQ};
   localparam logic [7:0] BLANKS [6] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR, CH_LF};

   logic                     clock;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   ltok_req_if req_chan();
   ltok_rsp_if rsp_chan();

   token_checker tok_chk = new();
   bit           tx_steady = 0;
   bit           rx_steady = 0;
   int           tx_count  = 0;

   logic_expression_tokenizer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Mostly short gaps, a few long ones
   function automatic int pick_gap(bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] rand_letter();
      int r;
      r = $urandom_range(0, 51);
      if (r < 26) return CH_UP_A + 8'(r);
      return CH_LO_A + 8'(r - 26);
   endfunction

   // One input transaction; valid stays high when the next one follows at once
   task automatic send_byte(input logic [7:0] c, input bit eoi);
      int gap;
      gap = pick_gap(tx_steady);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.char_code    <= c;
      req_chan.end_of_input <= eoi;
      do @(posedge clock); while (!req_chan.ready);
      tok_chk.take_byte(c, eoi);
      tx_count++;
   endtask

   // Well-formed piece of text with random content
   task automatic send_fragment();
      int         pick;
      int         n;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         send_byte(rand_letter(), 1'b0);
      end else if (pick < 45) begin
         send_byte(SINGLE_OPS[$urandom_range(0, 12)], 1'b0);
      end else if (pick < 60) begin
         case ($urandom_range(0, 4))
            0: begin send_byte(CH_AMP, 1'b0); send_byte(CH_AMP, 1'b0); end
            1: begin send_byte(CH_BAR, 1'b0); send_byte(CH_BAR, 1'b0); end
            2: begin send_byte(CH_DASH, 1'b0); send_byte(CH_GT, 1'b0); end
            3: begin send_byte(CH_EQ, 1'b0); send_byte(CH_EQ, 1'b0); end
            default: begin
               send_byte(CH_LT, 1'b0);
               send_byte(CH_DASH, 1'b0);
               send_byte(CH_GT, 1'b0);
            end
         endcase
      end else if (pick < 70) begin
         send_byte(PREFIXES[$urandom_range(0, 3)], 1'b0);
      end else if (pick < 85) begin
         send_byte(BLANKS[$urandom_range(0, 5)], 1'b0);
      end else if (pick < 92) begin
         // comment body takes any byte but newline
         send_byte(CH_HASH, 1'b0);
         n = $urandom_range(0, 6);
         repeat (n) begin
            do b = 8'($urandom); while (b == CH_LF);
            send_byte(b, 1'b0);
         end
         send_byte(CH_LF, 1'b0);
      end else begin
         send_byte(CH_BSLASH, 1'b0);
         if ($urandom_range(0, 3) == 0) send_byte(CH_LF, 1'b0);
         else send_byte(rand_letter(), 1'b0);
      end
   endtask

   // End or error are sticky, so the run closes with one of them, chosen at random
   task automatic finish_text();
      logic [7:0] b;
      send_byte(CH_SPACE, 1'b0);
      case ($urandom_range(0, 11))
         0: send_byte(8'($urandom), 1'b1);
         1: begin send_byte(CH_AMP, 1'b0); send_byte(8'($urandom), 1'b1); end
         2: begin send_byte(CH_DASH, 1'b0); send_byte(8'($urandom), 1'b1); end
         3: begin send_byte(CH_EQ, 1'b0); send_byte(8'($urandom), 1'b1); end
         4: begin send_byte(CH_LT, 1'b0); send_byte(8'($urandom), 1'b1); end
         5: begin
            send_byte(CH_LT, 1'b0);
            send_byte(CH_DASH, 1'b0);
            send_byte(8'($urandom), 1'b1);
         end
         6: begin
            do b = 8'($urandom); while (b == CH_DASH);
            send_byte(CH_LT, 1'b0);
            send_byte(b, 1'b0);
         end
         7: begin
            do b = 8'($urandom); while (b == CH_GT);
            send_byte(CH_LT, 1'b0);
            send_byte(CH_DASH, 1'b0);
            send_byte(b, 1'b0);
         end
         8: begin
            do b = 8'($urandom); while (b == CH_LF || tok_chk.is_alpha(b));
            send_byte(CH_BSLASH, 1'b0);
            send_byte(b, 1'b0);
         end
         9: begin send_byte(CH_BSLASH, 1'b0); send_byte(8'($urandom), 1'b1); end
         10: begin send_byte(CH_HASH, 1'b0); send_byte(8'($urandom), 1'b1); end
         default: begin
            if ($urandom_range(0, 1) == 0) b = 8'($urandom_range(128, 255));
            else b = 8'($urandom_range(48, 57));
            send_byte(b, 1'b0);
         end
      endcase
   endtask

   // Drain: input held off until every owed token has come, then pipeline settles
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (tok_chk.outstanding() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup then access
   task automatic csr_write(input logic idx, input logic [FIELD_BITS-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {16'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      tok_chk.write_reg(idx, value);
   endtask

   // Result side stalls
   initial begin
      int hold;
      hold = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            hold--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) hold = pick_gap(rx_steady);
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      tok_rec_type seen;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen.kind   = kind_type'(rsp_chan.token_kind);
         seen.status = status_type'(rsp_chan.status);
         seen.letter = rsp_chan.symbol_letter;
         seen.line   = rsp_chan.line_number;
         seen.column = rsp_chan.column_number;
         seen.last   = rsp_chan.last;
         tok_chk.match_token(seen);
      end
   end

   // Watchdog on cycles with no transaction on either channel
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("tb_top: FAIL");
      $finish;
   end

   // Stimulus
   initial begin
      logic [FIELD_BITS-1:0] ln;
      logic [FIELD_BITS-1:0] cl;
      int                    sent;
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.char_code    <= '0;
      req_chan.end_of_input <= 1'b0;
      psel                  <= 1'b0;
      penable               <= 1'b0;
      pwrite                <= 1'b0;
      paddr                 <= '0;
      pwdata                <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed text at the reset start position
      foreach (INTRO[i]) send_byte(INTRO[i], 1'b0);

      // random text under several start positions, extremes first
      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         case (ph)
            0: begin ln = 16'hFFFF; cl = 16'hFFFF; end
            1: begin ln = 16'h0000; cl = 16'h0000; end
            2: begin ln = 16'hFFFE; cl = 16'hFFF8; end
            default: begin
               ln = 16'($urandom);
               cl = 16'($urandom);
            end
         endcase
         csr_write(REG_START_LINE, ln);
         csr_write(REG_START_COLUMN, cl);
         tx_steady = (ph == 3);
         rx_steady = (ph == 3);
         sent = tx_count;
         while (tx_count - sent < PHASE_BYTES) send_fragment();
      end

      tx_steady = 1'b0;
      rx_steady = 1'b0;
      finish_text();

      // after end or error: raw bytes and end marks
      repeat (TAIL_BYTES) send_byte(8'($urandom), 1'($urandom_range(0, 1)));

      settle();
      if (tok_chk.errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

### logic_expression_tokenizer.f
src/ltok_pkg.sv
src/ltok_req_if.sv
src/ltok_rsp_if.sv
src/ltok_csr.sv
src/ltok_front.sv
src/ltok_queue.sv
src/ltok_back.sv
src/logic_expression_tokenizer.sv
tb/sv/ltok_tb_pkg.sv
tb/sv/tb_top.sv
